FILE: rtl/lfuwc_pkg.sv
// Shared constants, types and helpers for the LFU window cache lookup block.
`default_nettype none

package lfuwc_pkg;

    // Geometry of the tag store.
    localparam int WAYS   = 8;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int HIST_W = 8;
    localparam int CNT_W  = $clog2(HIST_W + 1);
    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;
    localparam int OFS_W  = 5;

    localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(2);

    // Search item that walks down the row of ways, one way per cycle.
    typedef struct packed {
        logic              vld;
        logic              hit_found;
        logic [WAY_W-1:0]  hit_way;
        logic              inv_found;
        logic [WAY_W-1:0]  inv_way;
        logic [WAY_W-1:0]  best_way;
        logic [CNT_W-1:0]  best_cnt;
        logic [TIME_W-1:0] best_time;
    } tok_t;

    // Update broadcast to all ways; the selected way takes it.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] tag;
        logic [TIME_W-1:0] time_val;
    } upd_t;

    // Number of set bits in an access history.
    function automatic logic [CNT_W-1:0] hist_count(input logic [HIST_W-1:0] h);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < HIST_W; i++) begin
            n = n + CNT_W'(h[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lfuwc_cell.sv
// One cache way: its state and one stage of the search chain.
`default_nettype none

module lfuwc_cell
    import lfuwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WAY_W-1:0]  idx,
    input  logic              shift,
    input  logic [ADDR_W-1:0] search_tag,
    input  tok_t              tok_in,
    output tok_t              tok_out,
    input  logic              wr_en,
    input  upd_t              upd,
    output logic              way_valid
);

    logic              valid_reg, valid_next;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [ADDR_W-1:0] tag_reg, tag_next;
    logic [TIME_W-1:0] time_reg, time_next;
    tok_t              tok_reg, tok_next;

    logic              match;
    logic [CNT_W-1:0]  cnt;

    // Way state: history ages on every access, the chosen way takes the update.
    always_comb
    begin
        valid_next = valid_reg;
        hist_next  = hist_reg;
        tag_next   = tag_reg;
        time_next  = time_reg;
        if (shift)
        begin
            hist_next = {hist_reg[HIST_W-2:0], 1'b0};
        end
        else if (wr_en)
        begin
            time_next = upd.time_val;
            if (upd.hit)
            begin
                hist_next = hist_reg | HIST_W'(1);
            end
            else
            begin
                valid_next = 1'b1;
                tag_next   = upd.tag;
                hist_next  = HIST_W'(1);
            end
        end
    end

    // Search stage: first hit, first empty way, and running victim choice.
    always_comb
    begin
        match    = valid_reg && (tag_reg == search_tag);
        cnt      = hist_count(hist_reg);
        tok_next = tok_in;
        if (tok_in.vld)
        begin
            if (!tok_in.hit_found && match)
            begin
                tok_next.hit_found = 1'b1;
                tok_next.hit_way   = idx;
            end
            if (!tok_in.inv_found && !valid_reg)
            begin
                tok_next.inv_found = 1'b1;
                tok_next.inv_way   = idx;
            end
            if ((cnt < tok_in.best_cnt) ||
                ((cnt == tok_in.best_cnt) && (time_reg < tok_in.best_time)))
            begin
                tok_next.best_way  = idx;
                tok_next.best_cnt  = cnt;
                tok_next.best_time = time_reg;
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hist_reg  <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hist_reg  <= hist_next;
            tok_reg   <= tok_next;
        end
    end

    // Tag and time are only read once the way is valid.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        time_reg <= time_next;
    end

    assign tok_out   = tok_reg;
    assign way_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/lfu_window_cache_lookup.sv
// Top level of the LFU window cache lookup: control, chain of ways, output register.
`default_nettype none

// Fully associative tag store with least-frequently-used replacement and an
// oldest-time tie break (then lowest way). Each accepted item (address,
// timestamp) yields one result (hit, way). The tag is the address shifted right
// by the offset register. Lookup is a search item that walks the row of
// WAYS way cells, one cell per cycle; the chosen way is updated as the item
// leaves the last cell and the result is loaded into the output register at the
// same time if it is free. A new item is accepted only once the last one has
// left the cell chain and its result is in the output register, so a stalled
// output holds off the next item. The offset register may be written only while
// no item is in flight; its ready is always high.

module lfu_window_cache_lookup
    import lfuwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ADDR_W-1:0] address,
    input  logic [TIME_W-1:0] timestamp,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [WAY_W-1:0]  way,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [OFS_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PEND = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [OFS_W-1:0]  ofs_reg, ofs_next;
    logic [ADDR_W-1:0] stag_reg, stag_next;
    logic [TIME_W-1:0] stime_reg, stime_next;
    tok_t              start_reg, start_next;
    logic              pend_hit_reg, pend_hit_next;
    logic [WAY_W-1:0]  pend_way_reg, pend_way_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [WAY_W-1:0]  out_way_reg, out_way_next;

    tok_t              tok [WAYS+1];
    logic [WAYS-1:0]   wr_en;
    logic [WAYS-1:0]   way_valid;
    logic [WAYS:0]     tok_vld;
    upd_t              upd;
    logic              accept;
    logic              scan_done;
    logic              out_free;
    logic              res_hit;
    logic [WAY_W-1:0]  slot;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign scan_done = tok[WAYS].vld;
    assign out_free  = !out_valid_reg || !out_stall;

    // Offset register.
    always_comb
    begin
        ofs_next = ofs_reg;
        if (cfg_valid && cfg_ready)
        begin
            ofs_next = cfg_data;
        end
    end

    // Capture the tag and time of a new item and launch the search.
    always_comb
    begin
        stag_next  = stag_reg;
        stime_next = stime_reg;
        start_next = '0;
        if (accept)
        begin
            stag_next           = address >> ofs_reg;
            stime_next          = timestamp;
            start_next.vld      = 1'b1;
            start_next.best_cnt = '1;
        end
    end

    assign tok[0] = start_reg;

    // Row of way cells.
    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        lfuwc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (WAY_W'(g)),
            .shift      (accept),
            .search_tag (stag_reg),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1]),
            .wr_en      (wr_en[g]),
            .upd        (upd),
            .way_valid  (way_valid[g])
        );
    end

    for (genvar g = 0; g <= WAYS; g++)
    begin : g_vld
        assign tok_vld[g] = tok[g].vld;
    end

    // Pick the way: hit first, then the first empty way, then the victim.
    always_comb
    begin
        res_hit = tok[WAYS].hit_found;
        if (tok[WAYS].hit_found)
        begin
            slot = tok[WAYS].hit_way;
        end
        else if (tok[WAYS].inv_found)
        begin
            slot = tok[WAYS].inv_way;
        end
        else
        begin
            slot = tok[WAYS].best_way;
        end
        upd.hit      = res_hit;
        upd.tag      = stag_reg;
        upd.time_val = stime_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            wr_en[i] = scan_done && (slot == WAY_W'(i));
        end
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        pend_hit_next  = pend_hit_reg;
        pend_way_next  = pend_way_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_hit_next   = out_hit_reg;
        out_way_next   = out_way_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_hit_next   = res_hit;
                        out_way_next   = slot;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pend_hit_next = res_hit;
                        pend_way_next = slot;
                        state_next    = S_PEND;
                    end
                end
            end
            S_PEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = pend_hit_reg;
                    out_way_next   = pend_way_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ofs_reg       <= OFS_RESET;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ofs_reg       <= ofs_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        stag_reg     <= stag_next;
        stime_reg    <= stime_next;
        pend_hit_reg <= pend_hit_next;
        pend_way_reg <= pend_way_next;
        out_hit_reg  <= out_hit_next;
        out_way_reg  <= out_way_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign way       = out_way_reg;

`ifndef SYNTHESIS
    // At most one search item is in the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_vld) <= 1)
        else $error("more than one search item in the way chain");

    // The search ends only while the sequencer is scanning.
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == S_SCAN))
        else $error("search ended outside the scan state");

    // A miss that finds no empty way only happens when every way is valid.
    a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_done && !tok[WAYS].hit_found && !tok[WAYS].inv_found) |-> (&way_valid))
        else $error("victim chosen while an empty way exists");

    // A new result appears only at the end of a search or from the pending slot.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(scan_done) || ($past(state_reg) == S_PEND)))
        else $error("result produced without a finished search");
`endif

endmodule

`default_nettype wire
